>>> hw/rtl/crlc_pkg.sv
`timescale 1ns / 1ps

package crlc_pkg;

  // Parser position within one list item
  typedef enum logic [2:0] {
    PH_START = 3'd0,
    PH_NUM1  = 3'd1,
    PH_EXP2  = 3'd2,
    PH_NUM2  = 3'd3,
    PH_COMMA = 3'd4
  } phase_t;

  localparam int unsigned OUT_COUNT_W = 24;
  localparam int unsigned CH_W        = 8;

  localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CH_W-1:0] CH_NL    = 8'h0A;
  localparam logic [CH_W-1:0] CH_VT    = 8'h0B;
  localparam logic [CH_W-1:0] CH_FF    = 8'h0C;
  localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE  = 8'h39;

  function automatic logic is_blank(input logic [CH_W-1:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL) ||
           (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
  endfunction

  function automatic logic is_digit(input logic [CH_W-1:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_line_end(input logic [CH_W-1:0] c);
    return (c == CH_NL) || (c == CH_NUL);
  endfunction

endpackage

>>> hw/rtl/cpu_range_list_counter_top.sv
`timescale 1ns / 1ps

// Channel | Dir | Fields (lowest bit up)                 | Accepted when
// s_*     | in  | tdata: ch[7:0]                         | s_tvalid && s_tready
// m_*     | out | tdata: cpu_count[23:0]                 | m_tvalid && m_tready
//         |     | tuser: line_done[0], parse_error[1]    |
//
// One byte per cycle while s_tready is high: each byte updates the parser state and
// its result lands in the output register on the next edge.
// The output register is the only buffer, so s_tready drops only while a result
// waits and m_tready is low.
// rst is synchronous, active high; it returns the parser to line start with a
// zero count and clears the error.
module cpu_range_list_counter_top #(
  parameter int unsigned NUM_WIDTH   = 16,
  parameter int unsigned COUNT_WIDTH = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // ch[7:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // cpu_count[23:0]
  output logic [1:0]  m_tuser    // line_done[0], parse_error[1]
);

  localparam int unsigned AW = NUM_WIDTH + 4;
  localparam int unsigned SW = ((COUNT_WIDTH > NUM_WIDTH) ? COUNT_WIDTH : NUM_WIDTH) + 2;

  crlc_pkg::phase_t       phase, phase_next;
  logic [NUM_WIDTH-1:0]   range_start, range_start_next;
  logic [NUM_WIDTH-1:0]   range_end, range_end_next;
  logic [COUNT_WIDTH-1:0] total, total_next;
  logic                   halted, halted_next;

  logic                   accept;
  logic                   dig, blk, lend, comma, minus;
  logic [NUM_WIDTH-1:0]   dval;
  logic                   do_finish, begin_first, begin_second, fail_hit, done;
  logic [NUM_WIDTH-1:0]   acc_start, acc_end, fin_end;
  logic [SW-1:0]          sum;
  logic [COUNT_WIDTH-1:0] added;
  logic [COUNT_WIDTH+crlc_pkg::OUT_COUNT_W-1:0] count_ext;

  function automatic logic [NUM_WIDTH-1:0] accumulate(input logic [NUM_WIDTH-1:0] v,
                                                      input logic [NUM_WIDTH-1:0] d);
    logic [AW-1:0] r;
    r = AW'({v, 3'b000}) + AW'({v, 1'b0}) + AW'(d);
    if (r > AW'({NUM_WIDTH{1'b1}})) begin
      return {NUM_WIDTH{1'b1}};
    end
    return r[NUM_WIDTH-1:0];
  endfunction

  assign accept   = s_tvalid && s_tready;
  assign s_tready = !m_tvalid || m_tready;

  assign dig   = crlc_pkg::is_digit(s_tdata);
  assign blk   = crlc_pkg::is_blank(s_tdata);
  assign lend  = crlc_pkg::is_line_end(s_tdata);
  assign comma = (s_tdata == crlc_pkg::CH_COMMA);
  assign minus = (s_tdata == crlc_pkg::CH_MINUS);
  assign dval  = NUM_WIDTH'(s_tdata[3:0]);

  // Next parser position
  always_comb begin
    phase_next = phase;
    if (!halted) begin
      case (phase)
        crlc_pkg::PH_NUM1: begin
          if (dig) phase_next = crlc_pkg::PH_NUM1;
          else if (minus) phase_next = crlc_pkg::PH_EXP2;
          else if (comma) phase_next = crlc_pkg::PH_COMMA;
          else if (lend || blk) phase_next = crlc_pkg::PH_START;
        end
        crlc_pkg::PH_EXP2: begin
          if (dig) phase_next = crlc_pkg::PH_NUM2;
        end
        crlc_pkg::PH_NUM2: begin
          if (comma) phase_next = crlc_pkg::PH_COMMA;
          else if (lend || blk) phase_next = crlc_pkg::PH_START;
          else if (!dig) phase_next = crlc_pkg::PH_NUM2;
          else if (dig) phase_next = crlc_pkg::PH_NUM2;
          if (!dig && !comma && !lend && !blk) phase_next = phase;
        end
        crlc_pkg::PH_COMMA: begin
          if (lend || blk) phase_next = crlc_pkg::PH_START;
          else if (dig) phase_next = crlc_pkg::PH_NUM1;
        end
        default: begin
          if (blk) phase_next = crlc_pkg::PH_START;
          else if (dig) phase_next = crlc_pkg::PH_NUM1;
        end
      endcase
      // Hold the position when a finished item is followed by a malformed byte
      if (((phase == crlc_pkg::PH_NUM1 && !minus) || phase == crlc_pkg::PH_NUM2) &&
          !dig && !comma && !lend && !blk) begin
        phase_next = phase;
      end
    end
  end

  // Datapath and result
  always_comb begin
    do_finish    = !halted && (((phase == crlc_pkg::PH_NUM1) && !dig && !minus) ||
                               ((phase == crlc_pkg::PH_NUM2) && !dig));
    begin_second = !halted && (phase == crlc_pkg::PH_EXP2);
    begin_first  = !halted && (((phase != crlc_pkg::PH_NUM1) &&
                                (phase != crlc_pkg::PH_EXP2) &&
                                (phase != crlc_pkg::PH_NUM2) &&
                                !((phase == crlc_pkg::PH_COMMA) && lend)) ||
                               (do_finish && !comma && !lend));
    fail_hit     = (begin_first || begin_second) && !blk && !dig;
    done         = !halted && lend && (do_finish || (phase == crlc_pkg::PH_COMMA));

    acc_start = accumulate(range_start, dval);
    acc_end   = accumulate(range_end, dval);
    fin_end   = (phase == crlc_pkg::PH_NUM1) ? range_start : range_end;

    sum = SW'(total) + SW'(fin_end - range_start) + SW'(1);
    if (fin_end < range_start) begin
      added = total;
    end else if (sum > SW'({COUNT_WIDTH{1'b1}})) begin
      added = {COUNT_WIDTH{1'b1}};
    end else begin
      added = sum[COUNT_WIDTH-1:0];
    end

    range_start_next = range_start;
    range_end_next   = range_end;
    total_next       = total;
    halted_next      = halted || fail_hit;

    if (!halted && (phase == crlc_pkg::PH_NUM1) && dig) range_start_next = acc_start;
    else if (begin_first && dig) range_start_next = dval;

    if (do_finish && (phase == crlc_pkg::PH_NUM1)) range_end_next = range_start;
    else if (!halted && (phase == crlc_pkg::PH_NUM2) && dig) range_end_next = acc_end;
    else if (begin_second && dig) range_end_next = dval;

    if (fail_hit) total_next = '0;
    else if (do_finish) total_next = added;

    count_ext = {{crlc_pkg::OUT_COUNT_W{1'b0}}, total_next};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= crlc_pkg::PH_START;
      range_start <= '0;
      range_end   <= '0;
      total       <= '0;
      halted      <= 1'b0;
    end else if (accept) begin
      phase       <= phase_next;
      range_start <= range_start_next;
      range_end   <= range_end_next;
      total       <= total_next;
      halted      <= halted_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= halted_next ? '0 : count_ext[crlc_pkg::OUT_COUNT_W-1:0];
      m_tuser <= {halted_next, done && !halted_next};
    end
  end

endmodule

>>> hw/rtl/crlc_checker.sv
`timescale 1ns / 1ps

module crlc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic [1:0]  m_tuser
);

  logic        pending;
  logic        seen_err;
  logic [23:0] last_count;
  logic        in_beat, out_beat;

  assign in_beat  = s_tvalid && s_tready;
  assign out_beat = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending    <= 1'b0;
      seen_err   <= 1'b0;
      last_count <= '0;
    end else begin
      if (in_beat) pending <= 1'b1;
      else if (out_beat) pending <= 1'b0;
      if (out_beat && m_tuser[1]) seen_err <= 1'b1;
      if (out_beat) last_count <= m_tdata;
    end
  end

  // Result valid only for a byte taken and not yet delivered
  a_valid_tracks_input: assert property (@(posedge clk) disable iff (rst)
    m_tvalid == pending)
    else $error("result valid does not match outstanding input beats");

  // Hold a stalled result
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed");

  // Error stays until reset, with the count forced to zero
  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    (out_beat && seen_err) |-> (m_tuser[1] && !m_tuser[0] && (m_tdata == 24'd0)))
    else $error("error flag dropped or count not cleared after error");

  // Count never falls while the line is well formed
  a_count_rises: assert property (@(posedge clk) disable iff (rst)
    (out_beat && !m_tuser[1]) |-> (m_tdata >= last_count))
    else $error("count decreased without error");

  // Accept no byte while a result is stuck
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !s_tready)
    else $error("input taken while result stalled");

endmodule

bind cpu_range_list_counter_top crlc_checker u_crlc_checker (.*);
